@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the RGB to HSV converter.
// Needs nothing else; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that, once seen, must be followed by a result in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/rgbhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// Used by rgbhsv_divider and rgb_to_hsv_converter; depends on nothing.
package rgbhsv_pkg;

    // Field widths.
    localparam int CH_W  = 8;
    localparam int HUE_W = 9;
    localparam int SAT_W = 8;

    // Divider geometry: numerators reach 255*255, quotients stay below 256.
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 8;
    localparam int DIV_QW    = 8;
    localparam int DIV_BPS   = 2;

    // Scale factors and hue offsets.
    localparam int SAT_SCALE     = 255;
    localparam int HUE_SECTOR    = 60;
    localparam int HUE_OFS_GREEN = 120;
    localparam int HUE_OFS_BLUE  = 240;
    localparam int HUE_FULL      = 360;

    // Which channel holds the maximum.
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } sel_t;

endpackage

@@ sv/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: takes one 8-bit RGB pixel per clock while pixel_stall is low and
// returns hue in whole degrees, saturation 0..255 and value. Throughput is one pixel per
// cycle while the output is not stalled. Each pixel passes the front register, the divider
// stages and the output register; two restoring dividers run side by side, one for
// saturation and one for hue. Every stage carries its own valid bit and fills any bubble
// ahead of it, so a stall on the output holds results without losing or repeating an item.
// Depends on rgbhsv_pkg, rgbhsv_divider and assert_macros.svh.
`include "assert_macros.svh"

module rgb_to_hsv_converter #(
    parameter int DIV_BITS_PER_STAGE = rgbhsv_pkg::DIV_BPS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic [rgbhsv_pkg::CH_W-1:0]  red,
    input  logic [rgbhsv_pkg::CH_W-1:0]  green,
    input  logic [rgbhsv_pkg::CH_W-1:0]  blue,
    output logic                         hsv_valid,
    input  logic                         hsv_stall,
    output logic [rgbhsv_pkg::HUE_W-1:0] hue_deg,
    output logic [rgbhsv_pkg::SAT_W-1:0] saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]  brightness
);

    localparam int CH_W   = rgbhsv_pkg::CH_W;
    localparam int HUE_W  = rgbhsv_pkg::HUE_W;
    localparam int NUM_W  = rgbhsv_pkg::DIV_NUM_W;
    localparam int QW     = rgbhsv_pkg::DIV_QW;
    localparam int STAGES = QW / DIV_BITS_PER_STAGE;

    // ------------------------------------------------------------------
    // Front stage: find max and min, the sector and the signed difference.
    // ------------------------------------------------------------------
    rgbhsv_pkg::sel_t sel_next;
    logic [CH_W-1:0]  mx_next;
    logic [CH_W-1:0]  mn_next;
    logic [CH_W-1:0]  diff_hi;
    logic [CH_W-1:0]  diff_lo;
    logic             neg_next;
    logic [CH_W-1:0]  mag_next;

    always_comb
    begin
        // Ties go to red first, then green.
        if (red >= green && red >= blue)
        begin
            sel_next = rgbhsv_pkg::SEL_RED;
        end
        else if (green >= blue)
        begin
            sel_next = rgbhsv_pkg::SEL_GREEN;
        end
        else
        begin
            sel_next = rgbhsv_pkg::SEL_BLUE;
        end

        mn_next = red;
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end

        unique case (sel_next)
            rgbhsv_pkg::SEL_RED:
            begin
                mx_next = red;
                diff_hi = green;
                diff_lo = blue;
            end
            rgbhsv_pkg::SEL_GREEN:
            begin
                mx_next = green;
                diff_hi = blue;
                diff_lo = red;
            end
            default:
            begin
                mx_next = blue;
                diff_hi = red;
                diff_lo = green;
            end
        endcase

        // Magnitude and sign of the in-sector difference.
        neg_next = (diff_hi < diff_lo);
        mag_next = neg_next ? (diff_lo - diff_hi) : (diff_hi - diff_lo);
    end

    logic             a_valid_reg;
    logic [CH_W-1:0]  a_mx_reg;
    logic [CH_W-1:0]  a_del_reg;
    logic [CH_W-1:0]  a_mag_reg;
    logic             a_neg_reg;
    rgbhsv_pkg::sel_t a_sel_reg;

    logic                  a_en;
    logic [STAGES-1:0]     div_en;
    logic                  out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_mx_reg  <= mx_next;
            a_del_reg <= mx_next - mn_next;
            a_mag_reg <= mag_next;
            a_neg_reg <= neg_next;
            a_sel_reg <= sel_next;
        end
    end

    // ------------------------------------------------------------------
    // Dividers: 255*del/max for saturation and 60*|diff|/del for hue.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] sat_num;
    logic [NUM_W-1:0] hue_num;
    logic [QW-1:0]    sat_quot;
    logic [QW-1:0]    hue_quot;
    logic             sat_rem_nz;
    logic             hue_rem_nz;

    assign sat_num = NUM_W'(a_del_reg) * NUM_W'(rgbhsv_pkg::SAT_SCALE);
    assign hue_num = NUM_W'(a_mag_reg) * NUM_W'(rgbhsv_pkg::HUE_SECTOR);

    rgbhsv_divider #(
        .NUM_W (NUM_W),
        .DEN_W (rgbhsv_pkg::DIV_DEN_W),
        .QW    (QW),
        .BPS   (DIV_BITS_PER_STAGE)
    ) u_sat_div (
        .clk    (clk),
        .adv    (div_en),
        .num    (sat_num),
        .den    (a_mx_reg),
        .quot   (sat_quot),
        .rem_nz (sat_rem_nz)
    );

    rgbhsv_divider #(
        .NUM_W (NUM_W),
        .DEN_W (rgbhsv_pkg::DIV_DEN_W),
        .QW    (QW),
        .BPS   (DIV_BITS_PER_STAGE)
    ) u_hue_div (
        .clk    (clk),
        .adv    (div_en),
        .num    (hue_num),
        .den    (a_del_reg),
        .quot   (hue_quot),
        .rem_nz (hue_rem_nz)
    );

    // Side data travels alongside the divider stages.
    logic [STAGES-1:0] d_valid_reg;
    logic [CH_W-1:0]   d_mx_reg  [STAGES];
    logic              d_neg_reg [STAGES];
    logic              d_dz_reg  [STAGES];
    rgbhsv_pkg::sel_t  d_sel_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_side
        logic             v_in;
        logic [CH_W-1:0]  mx_in;
        logic             neg_in;
        logic             dz_in;
        rgbhsv_pkg::sel_t sel_in;

        if (s == 0)
        begin : g_first
            assign v_in   = a_valid_reg;
            assign mx_in  = a_mx_reg;
            assign neg_in = a_neg_reg;
            assign dz_in  = (a_del_reg == '0);
            assign sel_in = a_sel_reg;
        end
        else
        begin : g_rest
            assign v_in   = d_valid_reg[s-1];
            assign mx_in  = d_mx_reg[s-1];
            assign neg_in = d_neg_reg[s-1];
            assign dz_in  = d_dz_reg[s-1];
            assign sel_in = d_sel_reg[s-1];
        end

        // A stage loads when it is empty or its successor moves on.
        if (s == STAGES - 1)
        begin : g_last_en
            assign div_en[s] = !d_valid_reg[s] || out_en;
        end
        else
        begin : g_mid_en
            assign div_en[s] = !d_valid_reg[s] || div_en[s+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[s] <= 1'b0;
            end
            else if (div_en[s])
            begin
                d_valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (div_en[s])
            begin
                d_mx_reg[s]  <= mx_in;
                d_neg_reg[s] <= neg_in;
                d_dz_reg[s]  <= dz_in;
                d_sel_reg[s] <= sel_in;
            end
        end
    end

    assign a_en        = !a_valid_reg || div_en[0];
    assign pixel_stall = !a_en;

    // ------------------------------------------------------------------
    // Output stage: add the sector offset, rounding down below it.
    // ------------------------------------------------------------------
    logic [HUE_W-1:0] hue_base;
    logic [HUE_W-1:0] hue_ceil;
    logic [HUE_W-1:0] hue_next;
    logic             l_neg;
    logic             l_dz;

    assign l_neg = d_neg_reg[STAGES-1];
    assign l_dz  = d_dz_reg[STAGES-1];

    always_comb
    begin
        unique case (d_sel_reg[STAGES-1])
            rgbhsv_pkg::SEL_RED:
            begin
                hue_base = l_neg ? HUE_W'(rgbhsv_pkg::HUE_FULL) : '0;
            end
            rgbhsv_pkg::SEL_GREEN:
            begin
                hue_base = HUE_W'(rgbhsv_pkg::HUE_OFS_GREEN);
            end
            default:
            begin
                hue_base = HUE_W'(rgbhsv_pkg::HUE_OFS_BLUE);
            end
        endcase

        // Below the offset the floor is the offset less the rounded-up quotient.
        hue_ceil = HUE_W'(hue_quot) + HUE_W'(hue_rem_nz);
        if (l_dz)
        begin
            hue_next = '0;
        end
        else if (l_neg)
        begin
            hue_next = hue_base - hue_ceil;
        end
        else
        begin
            hue_next = hue_base + HUE_W'(hue_quot);
        end
    end

    logic                         out_valid_reg;
    logic [HUE_W-1:0]             hue_reg;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_reg;
    logic [CH_W-1:0]              bri_reg;

    assign out_en = !out_valid_reg || !hsv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= d_valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            hue_reg <= hue_next;
            sat_reg <= l_dz ? '0 : rgbhsv_pkg::SAT_W'(sat_quot);
            bri_reg <= d_mx_reg[STAGES-1];
        end
    end

    assign hsv_valid  = out_valid_reg;
    assign hue_deg    = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

    // ------------------------------------------------------------------
    // Checks on the datapath and the stage control.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_hue_range, clk, rst_n, !hsv_valid || hue_deg < HUE_W'(rgbhsv_pkg::HUE_FULL))
    `ASSERT_ALWAYS(a_grey_hue, clk, rst_n, !(hsv_valid && saturation == '0) || hue_deg == '0)
    `ASSERT_ALWAYS(a_black_sat, clk, rst_n, !(hsv_valid && brightness == '0) || saturation == '0)
    `ASSERT_ALWAYS(a_stall_full, clk, rst_n, !pixel_stall || a_valid_reg)
    `ASSERT_NEXT(a_front_load, clk, rst_n, pixel_valid && !pixel_stall, a_valid_reg)

endmodule

@@ sv/rgbhsv_divider.sv @@
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Takes its default geometry from rgbhsv_pkg; rgb_to_hsv_converter hands the parameters down.
module rgbhsv_divider #(
    parameter int NUM_W = rgbhsv_pkg::DIV_NUM_W,
    parameter int DEN_W = rgbhsv_pkg::DIV_DEN_W,
    parameter int QW    = rgbhsv_pkg::DIV_QW,
    parameter int BPS   = rgbhsv_pkg::DIV_BPS
) (
    input  logic                    clk,
    input  logic [QW/BPS-1:0]       adv,
    input  logic [NUM_W-1:0]        num,
    input  logic [DEN_W-1:0]        den,
    output logic [QW-1:0]           quot,
    output logic                    rem_nz
);

    localparam int STAGES = QW / BPS;
    localparam int TW     = NUM_W + QW;

    logic [NUM_W-1:0] rem_reg  [STAGES];
    logic [QW-1:0]    quot_reg [STAGES];
    logic [DEN_W-1:0] den_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [QW-1:0]    quot_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] rem_next;
        logic [QW-1:0]    quot_next;

        // Stage inputs come from the ports or the previous stage.
        if (s == 0)
        begin : g_first
            assign rem_in  = num;
            assign quot_in = '0;
            assign den_in  = den;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign quot_in = quot_reg[s-1];
            assign den_in  = den_reg[s-1];
        end

        // Resolve BPS quotient bits, most significant first.
        always_comb
        begin
            logic [TW-1:0] trial;
            logic [TW-1:0] rem_wide;
            rem_wide  = TW'(rem_in);
            quot_next = quot_in;
            for (int j = 0; j < BPS; j++)
            begin
                trial = TW'(den_in) << (QW - 1 - (s * BPS + j));
                if (rem_wide >= trial)
                begin
                    rem_wide  = rem_wide - trial;
                    quot_next = {quot_next[QW-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_next[QW-2:0], 1'b0};
                end
            end
            rem_next = rem_wide[NUM_W-1:0];
        end

        // Stage registers advance under the stage's own enable.
        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= quot_next;
                den_reg[s]  <= den_in;
            end
        end
    end

    assign quot   = quot_reg[STAGES-1];
    assign rem_nz = (rem_reg[STAGES-1] != '0);

endmodule

@@ sim/tb_rgb_to_hsv_converter.sv @@
// Self-checking testbench for rgb_to_hsv_converter: directed and random pixels are pushed
// through the valid/stall handshake and every result is compared with a typed-in value or an integer predictor.
// Depends on rgbhsv_pkg and on the converter RTL with its divider.
module tb_rgb_to_hsv_converter;

    localparam int CH_W  = rgbhsv_pkg::CH_W;
    localparam int HUE_W = rgbhsv_pkg::HUE_W;
    localparam int SAT_W = rgbhsv_pkg::SAT_W;

    localparam int NUM_DIRECTED   = 22;
    localparam int PHASE_ITEMS    = 470;
    localparam int NUM_PHASES     = 4;
    localparam int HOLD_CYCLES    = 150;
    localparam int PRESSURE_ITEMS = 60;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 400000;

    // One HSV result as it leaves the block.
    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    // One row of the directed table; the result is typed in only where it is obvious.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        bit              typed;
        hsv_t            want;
    } pixel_case_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              pixel_valid = 1'b0;
    logic              pixel_stall;
    logic [CH_W-1:0]   red         = '0;
    logic [CH_W-1:0]   green       = '0;
    logic [CH_W-1:0]   blue        = '0;
    logic              hsv_valid;
    logic              hsv_stall   = 1'b0;
    logic [HUE_W-1:0]  hue_deg;
    logic [SAT_W-1:0]  saturation;
    logic [CH_W-1:0]   brightness;

    hsv_t pending_hsv [$];
    bit   cur_typed;
    hsv_t cur_want;
    int   send_gap_pct  = 0;
    int   stall_pct     = 0;
    bit   hold_request  = 1'b0;
    int   hold_left     = 0;
    int   cycle_count   = 0;
    int   pixels_sent   = 0;
    int   results_seen  = 0;
    int   error_count   = 0;

    pixel_case_t directed_cases [NUM_DIRECTED] = '{
        // Black, white and greys: no hue, no saturation.
        '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   8'd0,   8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{9'd0,   8'd0,   8'd128}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{9'd0,   8'd0,   8'd1}},
        // Primaries and the ties between two full channels.
        '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 8'd255, 8'd255}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 8'd255, 8'd255}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 8'd255, 8'd255}},
        // Red maximum with blue above green wraps the hue below zero; then other untyped corner pixels.
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd200, 8'd10,  8'd11,  1'b0, '0},
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{8'd0,   8'd1,   8'd0,   1'b0, '0},
        '{8'd0,   8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 1'b0, '0},
        '{8'd85,  8'd170, 8'd85,  1'b0, '0},
        '{8'd170, 8'd85,  8'd170, 1'b0, '0},
        '{8'd255, 8'd1,   8'd0,   1'b0, '0},
        '{8'd1,   8'd255, 8'd254, 1'b0, '0},
        '{8'd10,  8'd20,  8'd30,  1'b0, '0}
    };

    rgb_to_hsv_converter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hue_deg     (hue_deg),
        .saturation  (saturation),
        .brightness  (brightness)
    );

    // Free-running clock with a period of two time units.
    always #1 clk = ~clk;

    // Works out hue, saturation and value of one pixel with exact integer arithmetic.
    function automatic hsv_t hsv_from_rgb(input logic [CH_W-1:0] r, g, b);
        int               rv;
        int               gv;
        int               bv;
        int               peak;
        int               trough;
        int               span;
        int               k;
        int               num;
        int               q;
        rgbhsv_pkg::sel_t lead;
        hsv_t             res;
        rv = r;
        gv = g;
        bv = b;
        // Ties favour red, then green.
        if (rv >= gv && rv >= bv)
        begin
            peak = rv;
            lead = rgbhsv_pkg::SEL_RED;
        end
        else if (gv >= bv)
        begin
            peak = gv;
            lead = rgbhsv_pkg::SEL_GREEN;
        end
        else
        begin
            peak = bv;
            lead = rgbhsv_pkg::SEL_BLUE;
        end
        trough = (gv < rv) ? gv : rv;
        if (bv < trough)
            trough = bv;
        span = peak - trough;
        res.brightness = peak[CH_W-1:0];
        res.saturation = (peak == 0) ? '0 : SAT_W'((rgbhsv_pkg::SAT_SCALE * span) / peak);
        res.hue_deg    = '0;
        // A non-zero span always gives a non-zero saturation, so grey is the only hueless case.
        if (span > 0)
        begin
            case (lead)
                rgbhsv_pkg::SEL_RED:   k = gv - bv;
                rgbhsv_pkg::SEL_GREEN: k = 2 * span + bv - rv;
                default:               k = 4 * span + rv - gv;
            endcase
            num = rgbhsv_pkg::HUE_SECTOR * k;
            q = (num >= 0) ? num / span : -((-num + span - 1) / span);
            // Only the red sector can fall below zero, and never by more than one turn.
            if (q < 0)
                q = q + rgbhsv_pkg::HUE_FULL;
            res.hue_deg = q[HUE_W-1:0];
        end
        return res;
    endfunction

    // Channel level biased towards the extremes.
    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    // Offers one pixel, with a random gap before it, and waits until it is taken.
    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input bit typed, input hsv_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pixel_valid <= 1'b0;
            red         <= CH_W'($urandom_range(255));
            green       <= CH_W'($urandom_range(255));
            blue        <= CH_W'($urandom_range(255));
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        cur_typed    = typed;
        cur_want     = want;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Sends one random pixel, sometimes grey or with two channels tied.
    task automatic send_random_pixel();
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        r = pick_level();
        g = pick_level();
        b = pick_level();
        case ($urandom_range(15))
            0:
            begin
                g = r;
                b = r;
            end
            1:       g = r;
            2:       b = r;
            3:       b = g;
            default: ;
        endcase
        send_pixel(r, g, b, 1'b0, '0);
    endtask

    // Stops offering items until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hsv_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            hsv_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Every pixel taken by the block queues the result it must produce.
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            pending_hsv.push_back(cur_typed ? cur_want : hsv_from_rgb(red, green, blue));
    end

    // Every result taken from the block is compared with the oldest expectation.
    always @(posedge clk)
    begin
        hsv_t exp_hsv;
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            results_seen++;
            if (pending_hsv.size() == 0)
            begin
                $error("unexpected result: hue_deg %0d saturation %0d brightness %0d",
                       hue_deg, saturation, brightness);
                error_count++;
            end
            else
            begin
                exp_hsv = pending_hsv.pop_front();
                if (hue_deg !== exp_hsv.hue_deg)
                begin
                    $error("hue_deg: expected %0d, actual %0d", exp_hsv.hue_deg, hue_deg);
                    error_count++;
                end
                if (saturation !== exp_hsv.saturation)
                begin
                    $error("saturation: expected %0d, actual %0d",
                           exp_hsv.saturation, saturation);
                    error_count++;
                end
                if (brightness !== exp_hsv.brightness)
                begin
                    $error("brightness: expected %0d, actual %0d",
                           exp_hsv.brightness, brightness);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgb_to_hsv_converter verification failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases with different idling.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_pixel(directed_cases[i].red, directed_cases[i].green, directed_cases[i].blue,
                       directed_cases[i].typed, directed_cases[i].want);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 86;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 86;
                end
                default:
                begin
                    send_gap_pct = 25;
                    stall_pct    = 25;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // In the first phase the receiver holds off while the sender keeps going.
                if (phase == 0 && n == PHASE_ITEMS / 2)
                    hold_request = 1'b1;
                send_random_pixel();
            end
            if (phase == 0)
            begin
                hold_request = 1'b1;
                for (int n = 0; n < PRESSURE_ITEMS; n++)
                    send_random_pixel();
            end
            drain();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        error_count += pending_hsv.size();

        $display("Sent %0d pixels (%0d from the directed table) and checked %0d results",
                 pixels_sent, NUM_DIRECTED, results_seen);
        $display("Covered four idling phases and two long output hold-offs.");
        if (error_count == 0)
            $display("rgb_to_hsv_converter verification clean");
        else
            $display("rgb_to_hsv_converter verification failed");
        $finish;
    end

endmodule
